// ----- hw/rtl/htpa_pkg.sv -----
// Shared types and constants for the hit to pixel address block.
// Used by every module under hw/rtl; depends on nothing else.
`default_nettype none

package htpa_pkg;

	// field and datapath widths
	localparam int IN_W        = 21;  // x_pos / y_pos
	localparam int EDGE_W      = 26;  // signed chip edge positions
	localparam int D_W         = 22;  // offset of a hit from its chosen edge
	localparam int RECIP_W     = 26;
	localparam int PROD_W      = D_W + RECIP_W;
	localparam int RECIP_SHIFT = 24;
	localparam int LOC_W       = PROD_W - RECIP_SHIFT;  // local pixel, 8 fraction bits
	localparam int COL_W       = 4;
	localparam int ROW_W       = 4;
	localparam int PX_W        = 18;
	localparam int PY_W        = 17;
	localparam int TDATA_IN_W  = 48;
	localparam int TDATA_OUT_W = 48;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 21;
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = 2;

	// reciprocal pixel pitches, 2^24 / (16 * pitch_mm)
	localparam logic [RECIP_W-1:0] RECIP_X = 26'd35861012;
	localparam logic [RECIP_W-1:0] RECIP_Y = 26'd39009524;

	// register indexes on the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_FIRST_EDGE = 3'd0,
		REG_X_PITCH      = 3'd1,
		REG_Y_FIRST_EDGE = 3'd2,
		REG_Y_PITCH      = 3'd3,
		REG_MID_SHIFT    = 3'd4,
		REG_BACK_OFFSET  = 3'd5
	} cfg_reg_t;

	// register reset values
	localparam logic [20:0] RST_X_FIRST_EDGE = 21'h178A11; // -554479
	localparam logic [17:0] RST_X_PITCH      = 18'd123290;
	localparam logic [20:0] RST_Y_FIRST_EDGE = 21'h1ACE11; // -340463
	localparam logic [17:0] RST_Y_PITCH      = 18'd112230;
	localparam logic [15:0] RST_MID_SHIFT    = 16'd7373;
	localparam logic [17:0] RST_BACK_OFFSET  = 18'd56115;

	typedef struct packed {
		logic [20:0] x_first_edge;
		logic [17:0] x_pitch;
		logic [20:0] y_first_edge;
		logic [17:0] y_pitch;
		logic [15:0] mid_shift;
		logic [17:0] back_offset;
	} cfg_t;

	// one classified hit, handed from the front part to the back part
	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] frow;
		logic [ROW_W-1:0] brow;
		logic             col_ok;
		logic             frow_ok;
		logic             brow_ok;
		logic [D_W-1:0]   dx;
		logic [D_W-1:0]   dyf;
		logic [D_W-1:0]   dyb;
	} job_t;

	function automatic logic [EDGE_W-1:0] sext_in(input logic [IN_W-1:0] v);
		return {{(EDGE_W-IN_W){v[IN_W-1]}}, v};
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/htpa_front.sv -----
// Front part: edge tables, hit classification into column and row indexes,
// offsets from the chosen edges. Depends on htpa_pkg.
`default_nettype none

module htpa_front #(
	parameter int CHIP_COLUMNS = 9,
	parameter int CHIP_ROWS    = 6
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  htpa_pkg::cfg_t             cfg,
	input  wire                        in_valid,
	output logic                       in_ready,
	input  wire [htpa_pkg::IN_W-1:0]   in_x,
	input  wire [htpa_pkg::IN_W-1:0]   in_y,
	output logic                       out_valid,
	input  wire                        out_ready,
	output htpa_pkg::job_t             out_job
);

	localparam int EW   = htpa_pkg::EDGE_W;
	localparam int DW   = htpa_pkg::D_W;
	localparam int CCW  = $clog2(CHIP_COLUMNS + 1);
	localparam int RCW  = $clog2(CHIP_ROWS + 1);
	localparam int CIW  = (CHIP_COLUMNS > 1) ? $clog2(CHIP_COLUMNS) : 1;
	localparam int RIW  = (CHIP_ROWS > 1) ? $clog2(CHIP_ROWS) : 1;
	localparam int HALF = CHIP_ROWS / 2;

	logic [EW-1:0] xe_q [CHIP_COLUMNS];
	logic [EW-1:0] fe_q [CHIP_ROWS];
	logic [EW-1:0] be_q [CHIP_ROWS];

	// edge tables follow the registers in the following cycle
	for (genvar i = 0; i < CHIP_COLUMNS; i++) begin : g_xe
		always_ff @(posedge clk) begin
			xe_q[i] <= htpa_pkg::sext_in(cfg.x_first_edge) + EW'(cfg.x_pitch) * EW'(i);
		end
	end

	for (genvar i = 0; i < CHIP_ROWS; i++) begin : g_ye
		logic [EW-1:0] fe;
		assign fe = htpa_pkg::sext_in(cfg.y_first_edge) + EW'(cfg.y_pitch) * EW'(i)
			+ ((i >= HALF) ? EW'(cfg.mid_shift) : EW'(0));
		always_ff @(posedge clk) begin
			fe_q[i] <= fe;
			be_q[i] <= fe + EW'(cfg.back_offset);
		end
	end

	logic                       v_s1, v_s2;
	logic [htpa_pkg::IN_W-1:0]  x_s1, y_s1, x_s2, y_s2;
	logic [CIW-1:0]             xi_s2;
	logic [RIW-1:0]             fi_s2, bi_s2;
	logic                       xok_s2, fok_s2, bok_s2;
	logic                       en;

	assign en        = !v_s2 || out_ready;
	assign in_ready  = en;
	assign out_valid = v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	// stage 1: count edges strictly below the hit; edges rise, so the
	// count minus one picks the highest such edge
	logic [CCW-1:0] xcnt;
	logic [RCW-1:0] fcnt, bcnt;
	logic [EW-1:0]  xs1, ys1;

	always_comb begin
		xs1  = htpa_pkg::sext_in(x_s1);
		ys1  = htpa_pkg::sext_in(y_s1);
		xcnt = '0;
		fcnt = '0;
		bcnt = '0;
		for (int i = 0; i < CHIP_COLUMNS; i++) begin
			xcnt = xcnt + CCW'($signed(xe_q[i]) < $signed(xs1));
		end
		for (int i = 0; i < CHIP_ROWS; i++) begin
			fcnt = fcnt + RCW'($signed(fe_q[i]) < $signed(ys1));
			bcnt = bcnt + RCW'($signed(be_q[i]) < $signed(ys1));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= in_x;
			y_s1   <= in_y;
			x_s2   <= x_s1;
			y_s2   <= y_s1;
			xi_s2  <= CIW'(xcnt - CCW'(1));
			fi_s2  <= RIW'(fcnt - RCW'(1));
			bi_s2  <= RIW'(bcnt - RCW'(1));
			xok_s2 <= (xcnt != '0);
			fok_s2 <= (fcnt != '0);
			bok_s2 <= (bcnt != '0);
		end
	end

	// stage 2: offsets from the chosen edges
	logic [EW-1:0] xs2, ys2;

	always_comb begin
		xs2             = htpa_pkg::sext_in(x_s2);
		ys2             = htpa_pkg::sext_in(y_s2);
		out_job.col     = htpa_pkg::COL_W'(xi_s2);
		out_job.frow    = htpa_pkg::ROW_W'(fi_s2);
		out_job.brow    = htpa_pkg::ROW_W'(bi_s2);
		out_job.col_ok  = xok_s2;
		out_job.frow_ok = fok_s2;
		out_job.brow_ok = bok_s2;
		out_job.dx      = DW'(xs2 - xe_q[xi_s2]);
		out_job.dyf     = DW'(ys2 - fe_q[fi_s2]);
		out_job.dyb     = DW'(ys2 - be_q[bi_s2]);
	end

endmodule

`default_nettype wire

// ----- hw/rtl/htpa_queue.sv -----
// Short queue of classified hits between the front and back parts.
// Depends on htpa_pkg for the entry type and depth.
`default_nettype none

module htpa_queue (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             in_valid,
	output logic            in_ready,
	input  htpa_pkg::job_t  in_job,
	output logic            out_valid,
	input  wire             out_ready,
	output htpa_pkg::job_t  out_job
);

	localparam int PW = htpa_pkg::QPTR_W;
	localparam int CW = PW + 1;

	htpa_pkg::job_t mem_q [htpa_pkg::QDEPTH];
	logic [PW-1:0]  wr_q, rd_q;
	logic [CW-1:0]  cnt_q;
	logic           push, pop;

	assign in_ready  = (cnt_q != CW'(htpa_pkg::QDEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_job   = mem_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + PW'(1);
			if (pop)  rd_q <= rd_q + PW'(1);
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_job;
	end

endmodule

`default_nettype wire

// ----- hw/rtl/htpa_back.sv -----
// Back part: pixel scaling by the reciprocal pitches, range tests and
// emission of up to two results per hit. Depends on htpa_pkg.
`default_nettype none

module htpa_back #(
	parameter int PIX_COLS = 1024,
	parameter int PIX_ROWS = 512
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_ready,
	input  htpa_pkg::job_t                    in_job,
	output logic                              out_valid,
	input  wire                               out_ready,
	output logic [htpa_pkg::TDATA_OUT_W-1:0]  out_data,
	output logic                              out_last
);

	localparam int PW = htpa_pkg::PROD_W;
	localparam int LW = htpa_pkg::LOC_W;
	localparam int SH = htpa_pkg::RECIP_SHIFT;
	localparam logic [LW-1:0] LIM_X = LW'((PIX_COLS - 1) * 256);
	localparam logic [LW-1:0] LIM_Y = LW'((PIX_ROWS - 1) * 256);

	// product stage
	logic                    p_v_s3;
	htpa_pkg::job_t          job_s3;
	logic [PW-1:0]           px_s3, pyf_s3, pyb_s3;

	// emit stage: pending front and back results
	logic                         fv_q, bv_q;
	logic [htpa_pkg::COL_W-1:0]   col_q;
	logic [htpa_pkg::ROW_W-1:0]   frow_q, brow_q;
	logic [htpa_pkg::PX_W-1:0]    px_q;
	logic [htpa_pkg::PY_W-1:0]    pyf_q, pyb_q;

	logic e_free, p_adv, take, ok_x, ok_f, ok_b;
	logic [LW-1:0] lx, lyf, lyb;

	assign take     = out_valid && out_ready;
	assign e_free   = !(fv_q || bv_q) || (take && (fv_q != bv_q));
	assign p_adv    = p_v_s3 && e_free;
	assign in_ready = !p_v_s3 || e_free;

	assign lx   = px_s3[SH +: LW];
	assign lyf  = pyf_s3[SH +: LW];
	assign lyb  = pyb_s3[SH +: LW];
	assign ok_x = job_s3.col_ok && (lx <= LIM_X);
	assign ok_f = ok_x && job_s3.frow_ok && (lyf <= LIM_Y);
	assign ok_b = ok_x && job_s3.brow_ok && (lyb <= LIM_Y);

	// control of both stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_v_s3 <= 1'b0;
			fv_q   <= 1'b0;
			bv_q   <= 1'b0;
		end else begin
			if (in_ready) p_v_s3 <= in_valid;
			if (p_adv) begin
				fv_q <= ok_f;
				bv_q <= ok_b;
			end else if (take) begin
				if (fv_q) fv_q <= 1'b0;
				else      bv_q <= 1'b0;
			end
		end
	end

	// payload: one multiplier per offset, registered
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			job_s3 <= in_job;
			px_s3  <= PW'(in_job.dx)  * PW'(htpa_pkg::RECIP_X);
			pyf_s3 <= PW'(in_job.dyf) * PW'(htpa_pkg::RECIP_Y);
			pyb_s3 <= PW'(in_job.dyb) * PW'(htpa_pkg::RECIP_Y);
		end
		if (p_adv) begin
			col_q  <= job_s3.col;
			frow_q <= htpa_pkg::ROW_W'({job_s3.frow, 1'b0});
			brow_q <= htpa_pkg::ROW_W'({job_s3.brow, 1'b1});
			px_q   <= lx[htpa_pkg::PX_W-1:0];
			pyf_q  <= lyf[htpa_pkg::PY_W-1:0];
			pyb_q  <= lyb[htpa_pkg::PY_W-1:0];
		end
	end

	// front result goes out first, back result second
	assign out_valid = fv_q || bv_q;
	assign out_last  = !(fv_q && bv_q);
	assign out_data  = {5'd0,
		fv_q ? pyf_q : pyb_q,
		px_q,
		fv_q ? frow_q : brow_q,
		col_q};

endmodule

`default_nettype wire

// ----- hw/rtl/hit_to_pixel_address_top.sv -----
// Hit to pixel address, top level: configuration registers, front part,
// queue and back part. Depends on htpa_pkg, htpa_front, htpa_queue, htpa_back.
//
// Usage:
//   s_axis carries one hit per item (x_pos, y_pos, mm * 4096, signed).
//   m_axis returns zero, one or two pixel addresses per hit, front row first,
//   back row second; tlast marks the final result of a hit.
//   cfg writes register cfg_index with cfg_data; cfg_ready is always high.
//   Write registers only while no hit is in flight.
// Timing:
//   The first result of a hit passes front stages 1 and 2, the queue, then the
//   back part's product and emit stages. The front part takes one hit per cycle
//   while the queue has room; the back part holds a hit until each result it
//   gives is taken, so two-result hits are limited by the single result channel.
//   A four-entry queue between front and back absorbs bursts.
// Reset and stall:
//   arst_n clears all valid flags; registers return to their defaults.
//   When m_axis_tready is low the result holds, the back part stops, and the
//   front part keeps accepting until the queue is full.
`default_nettype none

module hit_to_pixel_address_top #(
	parameter int PIX_COLS     = 1024,
	parameter int PIX_ROWS     = 512,
	parameter int CHIP_COLUMNS = 9,
	parameter int CHIP_ROWS    = 6
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  s_axis_tvalid,
	output logic                                 s_axis_tready,
	// x_pos [20:0], y_pos [41:21], zero [47:42]
	input  wire  [htpa_pkg::TDATA_IN_W-1:0]      s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  wire                                  m_axis_tready,
	// chip_column [3:0], chip_row [7:4], pixel_x [25:8], pixel_y [42:26], zero [47:43]
	output logic [htpa_pkg::TDATA_OUT_W-1:0]     m_axis_tdata,
	output logic                                 m_axis_tlast,  // last_hit
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire  [htpa_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [htpa_pkg::CFG_DATA_W-1:0]      cfg_data
);

	htpa_pkg::cfg_t cfg_q;
	htpa_pkg::job_t fr_job, q_job;
	logic           fr_valid, fr_ready, q_valid, q_ready;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_first_edge <= htpa_pkg::RST_X_FIRST_EDGE;
			cfg_q.x_pitch      <= htpa_pkg::RST_X_PITCH;
			cfg_q.y_first_edge <= htpa_pkg::RST_Y_FIRST_EDGE;
			cfg_q.y_pitch      <= htpa_pkg::RST_Y_PITCH;
			cfg_q.mid_shift    <= htpa_pkg::RST_MID_SHIFT;
			cfg_q.back_offset  <= htpa_pkg::RST_BACK_OFFSET;
		end else if (cfg_valid) begin
			case (htpa_pkg::cfg_reg_t'(cfg_index))
				htpa_pkg::REG_X_FIRST_EDGE: cfg_q.x_first_edge <= cfg_data[20:0];
				htpa_pkg::REG_X_PITCH:      cfg_q.x_pitch      <= cfg_data[17:0];
				htpa_pkg::REG_Y_FIRST_EDGE: cfg_q.y_first_edge <= cfg_data[20:0];
				htpa_pkg::REG_Y_PITCH:      cfg_q.y_pitch      <= cfg_data[17:0];
				htpa_pkg::REG_MID_SHIFT:    cfg_q.mid_shift    <= cfg_data[15:0];
				htpa_pkg::REG_BACK_OFFSET:  cfg_q.back_offset  <= cfg_data[17:0];
				default: ;
			endcase
		end
	end

	htpa_front #(
		.CHIP_COLUMNS (CHIP_COLUMNS),
		.CHIP_ROWS    (CHIP_ROWS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_x      (s_axis_tdata[20:0]),
		.in_y      (s_axis_tdata[41:21]),
		.out_valid (fr_valid),
		.out_ready (fr_ready),
		.out_job   (fr_job)
	);

	htpa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_job    (fr_job),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_job   (q_job)
	);

	htpa_back #(
		.PIX_COLS (PIX_COLS),
		.PIX_ROWS (PIX_ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_ready  (q_ready),
		.in_job    (q_job),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

`default_nettype wire

// ----- hw/rtl/htpa_checker.sv -----
// Port-level checks on the hit to pixel address top level, bound to it.
// Depends on hit_to_pixel_address_top and htpa_pkg.
`default_nettype none

module htpa_checker #(
	parameter int PIX_COLS     = 1024,
	parameter int CHIP_COLUMNS = 9
) (
	input wire                                 clk,
	input wire                                 arst_n,
	input wire                                 m_axis_tvalid,
	input wire                                 m_axis_tready,
	input wire [htpa_pkg::TDATA_OUT_W-1:0]     m_axis_tdata,
	input wire                                 m_axis_tlast
);

	localparam logic [17:0] LIM_X = 18'((PIX_COLS - 1) * 256);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// a non-final result is always the front row (even chip_row)
	a_front_first: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[4] == 1'b0)
		else $error("non-final result is not a front row");

	// after a non-final result comes the back row of the same column
	a_back_follows: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
			m_axis_tvalid && m_axis_tlast && m_axis_tdata[4] == 1'b1
			&& m_axis_tdata[3:0] == $past(m_axis_tdata[3:0]))
		else $error("back row result missing after front row");

	// column index and pixel x stay in range
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[3:0] < 4'(CHIP_COLUMNS) || CHIP_COLUMNS > 15)
		else $error("chip column out of range");

	a_px_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[25:8] <= LIM_X || PIX_COLS > 1024)
		else $error("pixel x out of range");

endmodule

bind hit_to_pixel_address_top htpa_checker #(
	.PIX_COLS     (PIX_COLS),
	.CHIP_COLUMNS (CHIP_COLUMNS)
) u_htpa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ----- sim/tb_hit_to_pixel_address_top.sv -----
// Self-checking testbench for hit_to_pixel_address_top: hits go in on s_axis,
// pixel addresses come back on m_axis and are checked against a local predictor.
// Depends on htpa_pkg and the RTL under hw/rtl; needs nothing else.

module tb_hit_to_pixel_address_top;
	timeunit 1ns;
	timeprecision 1ps;

	import htpa_pkg::*;

	localparam int PIX_COLS     = 1024;
	localparam int PIX_ROWS     = 512;
	localparam int CHIP_COLUMNS = 9;
	localparam int CHIP_ROWS    = 6;

	// local pixel limits, 8 fraction bits
	localparam longint PX_LIMIT = longint'(PIX_COLS - 1) * 256;
	localparam longint PY_LIMIT = longint'(PIX_ROWS - 1) * 256;
	// largest offset from an edge that still passes the pixel range test
	localparam longint DX_MAX = (((PX_LIMIT + 1) << RECIP_SHIFT) - 1) / longint'(RECIP_X);
	localparam longint DY_MAX = (((PY_LIMIT + 1) << RECIP_SHIFT) - 1) / longint'(RECIP_Y);

	localparam longint POS_MIN = -1048576;
	localparam longint POS_MAX = 1048575;

	// register indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT   = 400000;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic [PX_W-1:0]  px;
		logic [PY_W-1:0]  py;
		logic             last;
	} pixel_addr_t;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [TDATA_IN_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [TDATA_OUT_W-1:0] m_axis_tdata;
	logic                   m_axis_tlast;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// shadow of the board registers, starts at the reset values
	cfg_t board = {RST_X_FIRST_EDGE, RST_X_PITCH, RST_Y_FIRST_EDGE, RST_Y_PITCH,
		RST_MID_SHIFT, RST_BACK_OFFSET};

	pixel_addr_t expected_addrs[$];
	int          errors = 0;
	int          src_gap_pct = 30;
	int          sink_stall_pct = 30;

	hit_to_pixel_address_top #(
		.PIX_COLS     (PIX_COLS),
		.PIX_ROWS     (PIX_ROWS),
		.CHIP_COLUMNS (CHIP_COLUMNS),
		.CHIP_ROWS    (CHIP_ROWS)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ---------------------------------------------------------------- board geometry

	function automatic longint col_edge(input int i);
		return longint'($signed(board.x_first_edge)) + longint'(i) * longint'(board.x_pitch);
	endfunction

	// front row edges; back rows sit back_offset higher, upper half adds mid_shift
	function automatic longint row_edge(input int i, input bit back_side);
		longint e;
		e = longint'($signed(board.y_first_edge)) + longint'(i) * longint'(board.y_pitch);
		if (back_side)
			e += longint'(board.back_offset);
		if (i >= CHIP_ROWS / 2)
			e += longint'(board.mid_shift);
		return e;
	endfunction

	// index of the last edge strictly below pos (-1 if none) and the offset from it
	function automatic int grid_slot(input longint pos, input bit is_row, input bit back_side,
			output longint offset);
		int     n;
		int     hits;
		longint e;
		longint chosen;
		n = is_row ? CHIP_ROWS : CHIP_COLUMNS;
		hits = 0;
		chosen = 0;
		for (int i = 0; i < n; i++) begin
			e = is_row ? row_edge(i, back_side) : col_edge(i);
			if (e < pos) begin
				hits++;
				chosen = e;
			end
		end
		offset = pos - chosen;
		return hits - 1;
	endfunction

	// queue the pixel addresses one hit should give: front row first, then back
	function automatic void predict_pixel_addrs(input logic [IN_W-1:0] xin,
			input logic [IN_W-1:0] yin);
		longint      dx;
		longint      dy;
		longint      px;
		longint      py;
		int          col;
		int          row;
		int          n;
		pixel_addr_t found[2];
		n = 0;
		col = grid_slot(longint'($signed(xin)), 1'b0, 1'b0, dx);
		if (col < 0)
			return;
		px = (dx * longint'(RECIP_X)) >> RECIP_SHIFT;
		if (px > PX_LIMIT)
			return;
		for (int side = 0; side < 2; side++) begin
			row = grid_slot(longint'($signed(yin)), 1'b1, side[0], dy);
			if (row < 0)
				continue;
			py = (dy * longint'(RECIP_Y)) >> RECIP_SHIFT;
			if (py > PY_LIMIT)
				continue;
			found[n].col  = col[COL_W-1:0];
			found[n].row  = ROW_W'(2 * row + side);
			found[n].px   = px[PX_W-1:0];
			found[n].py   = py[PY_W-1:0];
			found[n].last = 1'b0;
			n++;
		end
		if (n > 0)
			found[n-1].last = 1'b1;
		for (int k = 0; k < n; k++)
			expected_addrs.insert(expected_addrs.size(), found[k]);
	endfunction

	function automatic longint clamp_pos(input longint v);
		if (v > POS_MAX)
			return POS_MAX;
		if (v < POS_MIN)
			return POS_MIN;
		return v;
	endfunction

	// plausible board, or fully random register contents
	function automatic cfg_t make_board(input bit wide);
		cfg_t c;
		if (wide) begin
			c = {21'($urandom), 18'($urandom), 21'($urandom), 18'($urandom),
				16'($urandom), 18'($urandom)};
		end else begin
			c.x_first_edge = 21'(-700000 + int'($urandom_range(300000)));
			c.x_pitch      = 18'(100000 + $urandom_range(40000));
			c.y_first_edge = 21'(-400000 + int'($urandom_range(150000)));
			c.y_pitch      = 18'(90000 + $urandom_range(40000));
			c.mid_shift    = 16'($urandom);
			c.back_offset  = 18'(20000 + $urandom_range(60000));
		end
		return c;
	endfunction

	// ---------------------------------------------------------------- drivers

	// receiver: random stalls
	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

	// register write; cfg_valid stays high for a following write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_X_FIRST_EDGE: board.x_first_edge = data;
			REG_X_PITCH:      board.x_pitch      = data[17:0];
			REG_Y_FIRST_EDGE: board.y_first_edge = data;
			REG_Y_PITCH:      board.y_pitch      = data[17:0];
			REG_MID_SHIFT:    board.mid_shift    = data[15:0];
			REG_BACK_OFFSET:  board.back_offset  = data[17:0];
			default: ;
		endcase
	endtask

	// write all six registers, junk in the unused upper data bits
	task automatic load_board(input cfg_t c);
		logic [4:0] pad;
		pad = 5'($urandom);
		write_reg(REG_X_FIRST_EDGE, c.x_first_edge);
		write_reg(REG_X_PITCH, {pad[2:0], c.x_pitch});
		write_reg(REG_Y_FIRST_EDGE, c.y_first_edge);
		write_reg(REG_Y_PITCH, {pad[4:2], c.y_pitch});
		write_reg(REG_MID_SHIFT, {pad, c.mid_shift});
		write_reg(REG_BACK_OFFSET, {pad[3:1], c.back_offset});
		cfg_valid <= 1'b0;
	endtask

	// one hit item; expectations are queued when it is accepted
	task automatic send_hit(input longint x, input longint y);
		logic [IN_W-1:0] xb;
		logic [IN_W-1:0] yb;
		xb = x[IN_W-1:0];
		yb = y[IN_W-1:0];
		while ($urandom_range(99) < src_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'b0, yb, xb};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_pixel_addrs(xb, yb);
	endtask

	// drain: all results in, then room for hits that give none
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (expected_addrs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// random hit: noise, near an edge, or somewhere over the board
	task automatic pick_hit(output longint x, output longint y);
		int     sel;
		longint lo;
		longint hi;
		sel = int'($urandom_range(99));
		if (sel < 25) begin
			x = longint'($urandom_range(2097151)) + POS_MIN;
			y = longint'($urandom_range(2097151)) + POS_MIN;
		end else if (sel < 40) begin
			x = clamp_pos(col_edge(int'($urandom_range(CHIP_COLUMNS - 1)))
				+ longint'($urandom_range(4)) - 2);
			y = clamp_pos(row_edge(int'($urandom_range(CHIP_ROWS - 1)), 1'($urandom))
				+ longint'($urandom_range(4)) - 2);
		end else begin
			lo = clamp_pos(col_edge(0) - 2000);
			hi = clamp_pos(col_edge(CHIP_COLUMNS - 1) + DX_MAX + 2000);
			if (hi < lo)
				hi = lo;
			x = lo + longint'($urandom_range(32'(hi - lo)));
			lo = clamp_pos(row_edge(0, 1'b0) - 2000);
			hi = clamp_pos(row_edge(CHIP_ROWS - 1, 1'b1) + DY_MAX + 2000);
			if (hi < lo)
				hi = lo;
			y = lo + longint'($urandom_range(32'(hi - lo)));
		end
	endtask

	// ---------------------------------------------------------------- result check

	function automatic void note_mismatch(input string msg);
		errors++;
		if (errors <= 10)
			$display("%s", msg);
	endfunction

	always @(posedge clk) begin : result_check
		pixel_addr_t got;
		pixel_addr_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.col  = m_axis_tdata[3:0];
			got.row  = m_axis_tdata[7:4];
			got.px   = m_axis_tdata[25:8];
			got.py   = m_axis_tdata[42:26];
			got.last = m_axis_tlast;
			if (expected_addrs.size() == 0) begin
				note_mismatch($sformatf("unexpected result: col %0d row %0d px %0d py %0d last %0b",
					got.col, got.row, got.px, got.py, got.last));
			end else begin
				want = expected_addrs.pop_front();
				if (got !== want)
					note_mismatch($sformatf({"mismatch: expected col %0d row %0d px %0d py %0d ",
						"last %0b, got col %0d row %0d px %0d py %0d last %0b"},
						want.col, want.row, want.px, want.py, want.last,
						got.col, got.row, got.px, got.py, got.last));
			end
		end
	end

	// ---------------------------------------------------------------- tests

	// boundary hits on the board as it comes out of reset
	task automatic test_reset_defaults();
		longint xm;
		xm = col_edge(4) + 5000;
		send_hit(col_edge(0), row_edge(0, 1'b0) + 1);                 // on first column edge
		send_hit(col_edge(0) + 1, row_edge(0, 1'b0) + 1);             // just inside, front only
		send_hit(col_edge(8) + DX_MAX, row_edge(0, 1'b1) + DY_MAX);   // last column at limit
		send_hit(col_edge(8) + DX_MAX + 1, row_edge(0, 1'b0) + 1);    // beyond last column
		send_hit(col_edge(4), row_edge(1, 1'b0) + 10);                // on interior edge
		send_hit(col_edge(4) + 1, row_edge(0, 1'b1) + 10);            // front and back
		send_hit(xm, row_edge(0, 1'b0) + DY_MAX);
		send_hit(xm, row_edge(0, 1'b0) + DY_MAX + 1);                 // front too far, back ok
		send_hit(xm, row_edge(0, 1'b0));                              // on first row edge
		send_hit(xm, row_edge(3, 1'b0) + 1);                          // shifted upper row
		send_hit(xm, row_edge(3, 1'b0) - longint'(board.mid_shift) + 1);
		send_hit(xm, row_edge(5, 1'b1) + 1);                          // top back row
		send_hit(xm, row_edge(5, 1'b1) + DY_MAX + 1);                 // above the board
		send_hit(POS_MAX, POS_MAX);
		send_hit(POS_MIN, POS_MIN);
		send_hit(POS_MAX, row_edge(2, 1'b0) + 50);
		send_hit(xm, POS_MIN);
		send_hit(xm, POS_MAX);
		settle();
	endtask

	// zero pitches, edges at both ends of the range, largest offsets
	task automatic test_extreme_registers();
		load_board({21'h100000, 18'd0, 21'h100000, 18'd0, 16'd0, 18'd0});
		send_hit(POS_MIN, POS_MIN);
		send_hit(POS_MIN + 1, POS_MIN + 1);
		send_hit(POS_MIN + DX_MAX, POS_MIN + DY_MAX);
		send_hit(POS_MIN + DX_MAX + 1, POS_MIN + 1);
		send_hit(POS_MIN + 1, POS_MIN + DY_MAX + 1);
		settle();
		load_board({21'h0FFFFF, 18'h3FFFF, 21'h0FFFFF, 18'h3FFFF, 16'hFFFF, 18'h3FFFF});
		send_hit(POS_MAX, POS_MAX);
		send_hit(0, 0);
		settle();
		load_board({21'h100000, 18'h3FFFF, 21'h100000, 18'h3FFFF, 16'hFFFF, 18'h3FFFF});
		send_hit(POS_MAX, row_edge(5, 1'b1) + 1);
		send_hit(col_edge(4) + 1, row_edge(2, 1'b0) + 100);
		settle();
	endtask

	// writes to unused indexes change nothing; upper data bits are ignored
	task automatic test_register_writes();
		longint x;
		longint y;
		load_board(make_board(1'b0));
		// the write channel goes idle before the unused indexes
		@(posedge clk);
		write_reg(REG_UNUSED_LO, 21'($urandom));
		write_reg(REG_UNUSED_HI, 21'($urandom));
		write_reg(REG_UNUSED_LO, '1);
		cfg_valid <= 1'b0;
		repeat (12) begin
			pick_hit(x, y);
			send_hit(x, y);
		end
		settle();
	endtask

	// random hits over several boards and idle patterns
	task automatic test_random_hits();
		longint x;
		longint y;
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					src_gap_pct = 20;
					sink_stall_pct = 87;
				end
				1: begin
					src_gap_pct = 87;
					sink_stall_pct = 20;
				end
				default: begin
					src_gap_pct = 0;
					sink_stall_pct = 0;
				end
			endcase
			load_board(make_board(1'b0));
			repeat (300) begin
				pick_hit(x, y);
				send_hit(x, y);
			end
			settle();
			load_board(make_board(1'b1));
			repeat (160) begin
				pick_hit(x, y);
				send_hit(x, y);
			end
			settle();
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_extreme_registers();
		test_register_writes();
		test_random_hits();
		if (errors == 0 && expected_addrs.size() == 0)
			$display("hit_to_pixel_address_top test passed");
		else
			$display("hit_to_pixel_address_top test failed");
		$finish;
	end

	// watchdog
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("hit_to_pixel_address_top test failed");
		$finish;
	end

endmodule
